// ----- rtl/sm_div_pkg.sv -----
`timescale 1ns / 1ps

package sm_div_pkg;

    localparam int MAG_WIDTH      = 16;
    localparam int DIVIDEND_WIDTH = 2 * MAG_WIDTH;
    localparam int EA_WIDTH       = MAG_WIDTH + 1;
    localparam int COUNT_WIDTH    = 6;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam int REG_IDX_WIDTH  = 1;

    localparam logic [REG_IDX_WIDTH-1:0] REG_METHOD_SELECT = 1'b0;

    localparam logic METHOD_RESTORING    = 1'b0;
    localparam logic METHOD_NONRESTORING = 1'b1;

    localparam logic [COUNT_WIDTH-1:0] STEP_TOTAL = COUNT_WIDTH'(MAG_WIDTH);

    typedef struct packed {
        logic                      dividend_sign;
        logic [DIVIDEND_WIDTH-1:0] dividend_magnitude;
        logic                      divisor_sign;
        logic [MAG_WIDTH-1:0]      divisor_magnitude;
    } request_t;

    typedef struct packed {
        logic [MAG_WIDTH-1:0]   quotient_magnitude;
        logic                   quotient_sign;
        logic [MAG_WIDTH-1:0]   remainder_magnitude;
        logic                   remainder_sign;
        logic                   overflow_flag;
        logic [COUNT_WIDTH-1:0] step_count;
        logic [COUNT_WIDTH-1:0] addsub_count;
    } result_t;

    typedef struct packed {
        logic                   overflow;
        logic                   method;
        logic                   dividend_sign;
        logic                   divisor_sign;
        logic [EA_WIDTH-1:0]    ea;
        logic [MAG_WIDTH-1:0]   q;
        logic [MAG_WIDTH-1:0]   b;
        logic [COUNT_WIDTH-1:0] ops;
    } stage_t;

endpackage

// ----- rtl/sm_div_step.sv -----
`timescale 1ns / 1ps

module sm_div_step
    import sm_div_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  stage_t in_data,
    output logic   out_valid,
    output stage_t out_data
);

    logic                valid_reg;
    stage_t              data_reg;
    stage_t              data_next;
    logic [EA_WIDTH-1:0] shifted;
    logic [EA_WIDTH-1:0] sum;
    logic [EA_WIDTH-1:0] diff;
    logic [EA_WIDTH-1:0] b_ext;

    always_comb
    begin
        b_ext     = {1'b0, in_data.b};
        shifted   = {in_data.ea[MAG_WIDTH-1:0], in_data.q[MAG_WIDTH-1]};
        sum       = shifted + b_ext;
        diff      = shifted - b_ext;
        data_next = in_data;
        data_next.q = {in_data.q[MAG_WIDTH-2:0], 1'b0};
        if (in_data.method == METHOD_RESTORING)
        begin
            if (diff[MAG_WIDTH])
            begin
                data_next.ea  = shifted;
                data_next.ops = in_data.ops + COUNT_WIDTH'(2);
            end
            else
            begin
                data_next.ea   = diff;
                data_next.q[0] = 1'b1;
                data_next.ops  = in_data.ops + COUNT_WIDTH'(1);
            end
        end
        else
        begin
            data_next.ea   = in_data.ea[MAG_WIDTH] ? sum : diff;
            data_next.q[0] = ~data_next.ea[MAG_WIDTH];
            data_next.ops  = in_data.ops + COUNT_WIDTH'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- rtl/sign_magnitude_divider.sv -----
`timescale 1ns / 1ps
// done rises after the request passes the input register, the step stages and the done register.
// Throughput: one request per cycle; busy stays low, one stage per quotient bit.
// The result appears on the result port together with done and stays there until the next result.
// Reset clears the valid bits of every stage and selects restoring division.
// The receiver cannot stall; each new result overwrites the last one.

module sign_magnitude_divider
    import sm_div_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  request_t                  request,
    output logic                      done,
    output result_t                   result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_WIDTH-1:0] paddr,
    input  logic [APB_DATA_WIDTH-1:0] pwdata,
    output logic [APB_DATA_WIDTH-1:0] prdata,
    output logic                      pready
);

    logic                     method_reg;
    logic [REG_IDX_WIDTH-1:0] reg_idx;
    logic                     accept;
    logic                     s0_valid_reg;
    stage_t                   s0_data_reg;
    stage_t                   s0_next;
    logic                     pipe_valid [MAG_WIDTH+1];
    stage_t                   pipe_data  [MAG_WIDTH+1];
    logic                     done_reg;
    result_t                  result_reg;
    result_t                  result_next;
    stage_t                   last;
    logic                     fix;
    logic [EA_WIDTH-1:0]      ea_final;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign accept  = start & ~busy;
    assign reg_idx = paddr[APB_ADDR_WIDTH-1 -: REG_IDX_WIDTH];

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_METHOD_SELECT)
        begin
            prdata[0] = method_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            method_reg <= METHOD_RESTORING;
        end
        else if (psel && penable && pwrite && pready && reg_idx == REG_METHOD_SELECT)
        begin
            method_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        s0_next.overflow      = request.dividend_magnitude[DIVIDEND_WIDTH-1:MAG_WIDTH]
                                >= request.divisor_magnitude;
        s0_next.method        = method_reg;
        s0_next.dividend_sign = request.dividend_sign;
        s0_next.divisor_sign  = request.divisor_sign;
        s0_next.ea            = {1'b0, request.dividend_magnitude[DIVIDEND_WIDTH-1:MAG_WIDTH]};
        s0_next.q             = request.dividend_magnitude[MAG_WIDTH-1:0];
        s0_next.b             = request.divisor_magnitude;
        s0_next.ops           = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_data_reg <= s0_next;
        end
    end

    assign pipe_valid[0] = s0_valid_reg;
    assign pipe_data[0]  = s0_data_reg;

    for (genvar i = 0; i < MAG_WIDTH; i++)
    begin : g_step
        sm_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (pipe_valid[i]),
            .in_data   (pipe_data[i]),
            .out_valid (pipe_valid[i+1]),
            .out_data  (pipe_data[i+1])
        );
    end

    always_comb
    begin
        last     = pipe_data[MAG_WIDTH];
        fix      = (last.method == METHOD_NONRESTORING) & last.ea[MAG_WIDTH];
        ea_final = fix ? last.ea + {1'b0, last.b} : last.ea;
        if (last.overflow)
        begin
            result_next               = '0;
            result_next.overflow_flag = 1'b1;
        end
        else
        begin
            result_next.quotient_magnitude  = last.q;
            result_next.quotient_sign       = last.dividend_sign ^ last.divisor_sign;
            result_next.remainder_magnitude = ea_final[MAG_WIDTH-1:0];
            result_next.remainder_sign      = last.dividend_sign;
            result_next.overflow_flag       = 1'b0;
            result_next.step_count          = STEP_TOTAL + COUNT_WIDTH'(fix);
            result_next.addsub_count        = last.ops + COUNT_WIDTH'(fix);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pipe_valid[MAG_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_valid[MAG_WIDTH])
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
